@@ rtl/stepper_reply_frame_parser_core_macros.svh @@
// Assertion macros shared by the checker of the reply frame parser.
`ifndef STEPPER_REPLY_FRAME_PARSER_CORE_MACROS_SVH
`define STEPPER_REPLY_FRAME_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfp assertion failed");

`endif

@@ rtl/srfp_pkg.sv @@
// Package with the types, constants and decode functions of the reply frame parser.
package srfp_pkg;

    localparam int WIN_LEN     = 6;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAG_W       = 16;
    localparam int SPD_W       = 17;
    localparam int CFG_IDX_W   = 2;

    localparam int unsigned SPEED_SCALE = 10;
    localparam int DIV_SHIFT  = 24;
    localparam int RECIP_W    = DIV_SHIFT + 1;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / SPEED_SCALE);
    localparam logic [7:0] SCALE_B = 8'(SPEED_SCALE);

    localparam logic [7:0] CHECK_BYTE   = 8'h6B;
    localparam logic [7:0] CMD_SPEED    = 8'h35;
    localparam logic [7:0] CMD_4A       = 8'h4A;
    localparam logic [7:0] CMD_F3       = 8'hF3;
    localparam logic [7:0] CMD_F5       = 8'hF5;
    localparam logic [7:0] CMD_F6       = 8'hF6;
    localparam logic [7:0] CMD_FB       = 8'hFB;
    localparam logic [7:0] CMD_FD       = 8'hFD;
    localparam logic [7:0] CMD_93       = 8'h93;
    localparam logic [7:0] CMD_9A       = 8'h9A;
    localparam logic [7:0] CMD_9C       = 8'h9C;
    localparam logic [7:0] STS_OK       = 8'h02;
    localparam logic [7:0] STS_BUSY     = 8'h12;
    localparam logic [7:0] STS_ERR_PARM = 8'hE2;
    localparam logic [7:0] STS_ERR_FRM  = 8'hEE;
    localparam logic [7:0] STS_DONE     = 8'h9F;
    localparam logic [7:0] DIR_NEG      = 8'h00;
    localparam logic [7:0] DIR_POS      = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_X  = 2'd2;

    localparam logic [7:0] TIMEOUT_RST = 8'd3;
    localparam logic [7:0] ADDR_Y_RST  = 8'd1;
    localparam logic [7:0] ADDR_X_RST  = 8'd2;

    localparam logic [1:0] ACC_NONE   = 2'd0;
    localparam logic [1:0] ACC_STATUS = 2'd1;
    localparam logic [1:0] ACC_SPEED  = 2'd2;

    typedef enum logic [1:0] {
        FN_BYTE  = 2'd0,
        FN_TICK  = 2'd1,
        FN_STALE = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MUL,
        BK_FIX,
        BK_OUT
    } bk_state_t;

    function automatic logic is_cmd(input logic [7:0] b);
        return b inside {CMD_4A, CMD_F3, CMD_F5, CMD_F6, CMD_FB, CMD_FD,
                         CMD_93, CMD_9A, CMD_9C, CMD_SPEED};
    endfunction

    function automatic logic is_status(input logic [7:0] b);
        return b inside {STS_OK, STS_BUSY, STS_ERR_PARM, STS_ERR_FRM, STS_DONE};
    endfunction

endpackage

@@ rtl/srfp_if.sv @@
// Handshake interfaces for the request, result and configuration channels.
interface srfp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface srfp_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         accepted;
    logic               axis;
    logic [7:0]         status_code;
    logic               status_error;
    logic [31:0]        error_total;
    logic signed [16:0] speed_raw;
    logic signed [16:0] speed_rpm;
    logic [2:0]         window_fill;
    modport source (output valid, output accepted, output axis, output status_code,
                    output status_error, output error_total, output speed_raw,
                    output speed_rpm, output window_fill, input ready);
    modport sink (input valid, input accepted, input axis, input status_code,
                  input status_error, input error_total, input speed_raw,
                  input speed_rpm, input window_fill, output ready);
endinterface

interface srfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [7:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

@@ rtl/stepper_reply_frame_parser_core.sv @@
// Top level of the stepper reply frame parser.
// Every item gives exactly one result. Items enter a two-deep queue, so two can be
// taken while the parser works. The back end takes one item at a time: a tick, a
// stale check or a clear of the diagnostics passes from the queue head through the
// idle and output states to the result register; a received byte is stored in the
// idle state, then takes one scan step per window check (at most seven, as each check
// either drops one byte, accepts a reply or stops the scan), the multiply and fix
// steps of the constant divider on a speed reply, and the output state to load the
// result. A result that has not been taken holds the back end in its load step.
// Configuration writes are always taken and must only be made while the block is idle.
module stepper_reply_frame_parser_core (
    input logic        clk,
    input logic        rst_n,
    srfp_req_if.sink   req,
    srfp_rsp_if.source rsp,
    srfp_cfg_if.sink   cfg
);
    import srfp_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    srfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    srfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

@@ rtl/srfp_front.sv @@
// Front end: accepts items, classifies them and holds them in a short queue.
module srfp_front (
    input  logic          clk,
    input  logic          rst_n,
    srfp_req_if.sink      req,
    output logic          q_valid,
    output srfp_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import srfp_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;
    cmd_t              in_cmd;

    assign req.ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (fill_reg != '0);
    assign q_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.data = req.rx_byte;
        in_cmd.func = func_t'(req.func);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/srfp_back.sv @@
// Back end: window, resynchronising scan, speed divider, diagnostics and result register.
module srfp_back (
    input  logic           clk,
    input  logic           rst_n,
    srfp_cfg_if.sink       cfg,
    input  logic           q_valid,
    input  srfp_pkg::cmd_t q_cmd,
    output logic           q_pop,
    srfp_rsp_if.source     rsp
);
    import srfp_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [7:0]         win_reg [WIN_LEN];
    logic [7:0]         win_next [WIN_LEN];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         silence_reg, silence_next;
    logic [7:0]         last_status_reg, last_status_next;
    logic [31:0]        err_cnt_reg, err_cnt_next;
    logic [7:0]         timeout_reg, addr_y_reg, addr_x_reg;
    logic [1:0]         acc_reg, acc_next;
    logic               axis_reg, axis_next;
    logic               serr_reg, serr_next;
    logic signed [SPD_W-1:0] raw_reg, raw_next;
    logic signed [SPD_W-1:0] rpm_reg, rpm_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [MAG_W-1:0]   q0_reg, q0_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [1:0]         out_acc_reg;
    logic               out_axis_reg;
    logic [7:0]         out_status_reg;
    logic               out_serr_reg;
    logic [31:0]        out_err_reg;
    logic signed [SPD_W-1:0] out_raw_reg, out_rpm_reg;
    logic [CNT_W-1:0]   out_fill_reg;
    logic [PROD_W-1:0]  prod;
    logic [MAG_W+7:0]   qs;
    logic [MAG_W-1:0]   rem;
    logic [MAG_W-1:0]   quot;
    logic               drop1;
    logic               drop4;
    logic               is_err;

    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.accepted     = out_acc_reg;
    assign rsp.axis         = out_axis_reg;
    assign rsp.status_code  = out_status_reg;
    assign rsp.status_error = out_serr_reg;
    assign rsp.error_total  = out_err_reg;
    assign rsp.speed_raw    = out_raw_reg;
    assign rsp.speed_rpm    = out_rpm_reg;
    assign rsp.window_fill  = out_fill_reg;

    assign prod   = PROD_W'(mag_reg) * PROD_W'(RECIP);
    assign qs     = (MAG_W + 8)'(q0_reg) * (MAG_W + 8)'(SCALE_B);
    assign rem    = mag_reg - qs[MAG_W-1:0];
    assign quot   = (rem >= MAG_W'(SCALE_B)) ? q0_reg + 1'b1 : q0_reg;
    assign is_err = (win_reg[2] == STS_ERR_PARM) || (win_reg[2] == STS_ERR_FRM);

    always_comb
    begin
        state_next       = state_reg;
        win_next         = win_reg;
        cnt_next         = cnt_reg;
        silence_next     = silence_reg;
        last_status_next = last_status_reg;
        err_cnt_next     = err_cnt_reg;
        acc_next         = acc_reg;
        axis_next        = axis_reg;
        serr_next        = serr_reg;
        raw_next         = raw_reg;
        rpm_next         = rpm_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        q0_next          = q0_reg;
        q_pop            = 1'b0;
        out_load         = 1'b0;
        drop1            = 1'b0;
        drop4            = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    acc_next   = ACC_NONE;
                    axis_next  = 1'b0;
                    serr_next  = 1'b0;
                    raw_next   = '0;
                    rpm_next   = '0;
                    state_next = BK_OUT;
                    case (q_cmd.func)
                        FN_BYTE:
                        begin
                            silence_next = '0;
                            state_next   = BK_SCAN;
                            if (cnt_reg == CNT_W'(WIN_LEN))
                            begin
                                for (int i = 0; i < WIN_LEN - 1; i++)
                                begin
                                    win_next[i] = win_reg[i + 1];
                                end
                                win_next[WIN_LEN - 1] = q_cmd.data;
                            end
                            else
                            begin
                                win_next[cnt_reg] = q_cmd.data;
                                cnt_next          = cnt_reg + 1'b1;
                            end
                        end
                        FN_TICK:
                        begin
                            if (silence_reg != 8'hFF)
                            begin
                                silence_next = silence_reg + 1'b1;
                            end
                        end
                        FN_STALE:
                        begin
                            if ((cnt_reg != '0) && (silence_reg >= timeout_reg))
                            begin
                                cnt_next     = '0;
                                silence_next = '0;
                            end
                        end
                        FN_CLEAR:
                        begin
                            last_status_next = '0;
                            err_cnt_next     = '0;
                        end
                        default:
                        begin
                            state_next = BK_OUT;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_OUT;
                end
                else if ((win_reg[0] != addr_y_reg) && (win_reg[0] != addr_x_reg))
                begin
                    drop1 = 1'b1;
                end
                else if (cnt_reg < CNT_W'(2))
                begin
                    state_next = BK_OUT;
                end
                else if (!is_cmd(win_reg[1]))
                begin
                    drop1 = 1'b1;
                end
                else if (win_reg[1] == CMD_SPEED)
                begin
                    if (cnt_reg < CNT_W'(WIN_LEN))
                    begin
                        state_next = BK_OUT;
                    end
                    else if (((win_reg[2] != DIR_NEG) && (win_reg[2] != DIR_POS)) ||
                             (win_reg[5] != CHECK_BYTE))
                    begin
                        drop1 = 1'b1;
                    end
                    else
                    begin
                        mag_next   = {win_reg[3], win_reg[4]};
                        neg_next   = (win_reg[2] == DIR_NEG);
                        axis_next  = (win_reg[0] != addr_y_reg);
                        state_next = BK_MUL;
                    end
                end
                else if (cnt_reg < CNT_W'(3))
                begin
                    state_next = BK_OUT;
                end
                else if (!is_status(win_reg[2]))
                begin
                    drop1 = 1'b1;
                end
                else if (cnt_reg < CNT_W'(4))
                begin
                    state_next = BK_OUT;
                end
                else if (win_reg[3] != CHECK_BYTE)
                begin
                    drop1 = 1'b1;
                end
                else
                begin
                    last_status_next = win_reg[2];
                    acc_next         = ACC_STATUS;
                    axis_next        = (win_reg[0] != addr_y_reg);
                    raw_next         = '0;
                    rpm_next         = '0;
                    serr_next        = is_err;
                    if (is_err && (err_cnt_reg != '1))
                    begin
                        err_cnt_next = err_cnt_reg + 1'b1;
                    end
                    drop4 = 1'b1;
                end

                if (drop1)
                begin
                    for (int i = 0; i < WIN_LEN - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
                if (drop4)
                begin
                    for (int i = 0; i < WIN_LEN - 4; i++)
                    begin
                        win_next[i] = win_reg[i + 4];
                    end
                    cnt_next = cnt_reg - CNT_W'(4);
                end
            end
            BK_MUL:
            begin
                q0_next    = prod[DIV_SHIFT +: MAG_W];
                state_next = BK_FIX;
            end
            BK_FIX:
            begin
                acc_next   = ACC_SPEED;
                serr_next  = 1'b0;
                cnt_next   = '0;
                state_next = BK_SCAN;
                if (neg_reg)
                begin
                    raw_next = -$signed({1'b0, mag_reg});
                    rpm_next = -$signed({1'b0, quot});
                end
                else
                begin
                    raw_next = $signed({1'b0, mag_reg});
                    rpm_next = $signed({1'b0, quot});
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            cnt_reg         <= '0;
            silence_reg     <= '0;
            last_status_reg <= '0;
            err_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            timeout_reg     <= TIMEOUT_RST;
            addr_y_reg      <= ADDR_Y_RST;
            addr_x_reg      <= ADDR_X_RST;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            silence_reg     <= silence_next;
            last_status_reg <= last_status_next;
            err_cnt_reg     <= err_cnt_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.addr)
                    REG_TIMEOUT: timeout_reg <= cfg.data;
                    REG_ADDR_Y:  addr_y_reg  <= cfg.data;
                    REG_ADDR_X:  addr_x_reg  <= cfg.data;
                    default:     timeout_reg <= timeout_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        acc_reg  <= acc_next;
        axis_reg <= axis_next;
        serr_reg <= serr_next;
        raw_reg  <= raw_next;
        rpm_reg  <= rpm_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        q0_reg   <= q0_next;
        if (out_load)
        begin
            out_acc_reg    <= acc_reg;
            out_axis_reg   <= axis_reg;
            out_status_reg <= last_status_reg;
            out_serr_reg   <= serr_reg;
            out_err_reg    <= err_cnt_reg;
            out_raw_reg    <= raw_reg;
            out_rpm_reg    <= rpm_reg;
            out_fill_reg   <= cnt_reg;
        end
    end

endmodule

@@ rtl/srfp_checker.sv @@
// Port checker for the reply frame parser, bound to the top level.
`include "stepper_reply_frame_parser_core_macros.svh"

module srfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  accepted,
    input logic        axis,
    input logic        status_error,
    input logic [16:0] speed_raw,
    input logic [16:0] speed_rpm,
    input logic [2:0]  window_fill
);
    import srfp_pkg::*;

    logic speed_zero;
    logic none_rsp;
    logic none_clean;
    logic status_rsp;
    logic other_rsp;
    logic speed_clean;

    assign speed_zero  = (speed_raw == '0) && (speed_rpm == '0);
    assign none_rsp    = rsp_valid && (accepted == ACC_NONE);
    assign none_clean  = !axis && !status_error && speed_zero;
    assign status_rsp  = rsp_valid && (accepted == ACC_STATUS);
    assign other_rsp   = rsp_valid && (accepted != ACC_NONE) && (accepted != ACC_STATUS);
    assign speed_clean = (accepted == ACC_SPEED) && !status_error;

    `SRFP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `SRFP_ASSERT_SAME(a_fill_max, clk, rst_n, rsp_valid, window_fill <= 3'(WIN_LEN - 1))
    `SRFP_ASSERT_SAME(a_none_clean, clk, rst_n, none_rsp, none_clean)
    `SRFP_ASSERT_SAME(a_status_no_speed, clk, rst_n, status_rsp, speed_zero)
    `SRFP_ASSERT_SAME(a_speed_kind, clk, rst_n, other_rsp, speed_clean)

endmodule

bind stepper_reply_frame_parser_core srfp_checker u_srfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .accepted     (rsp.accepted),
    .axis         (rsp.axis),
    .status_error (rsp.status_error),
    .speed_raw    (rsp.speed_raw),
    .speed_rpm    (rsp.speed_rpm),
    .window_fill  (rsp.window_fill)
);

@@ dv/stepper_reply_frame_parser_core_test.sv @@
// Self-checking testbench for the stepper reply frame parser: directed frames, then random traffic.
`timescale 1ns / 100ps

import srfp_pkg::*;

typedef struct packed {
    logic [1:0]         accepted;
    logic               axis;
    logic [7:0]         status_code;
    logic               status_error;
    logic [31:0]        error_total;
    logic signed [16:0] speed_raw;
    logic signed [16:0] speed_rpm;
    logic [2:0]         window_fill;
} parse_result_t;

class reply_scoreboard;
    logic [7:0]    timeout_ms;
    logic [7:0]    addr_y;
    logic [7:0]    addr_x;
    logic [7:0]    win [WIN_LEN];
    int unsigned   fill;
    logic [7:0]    silence;
    logic [7:0]    last_status;
    logic [31:0]   err_count;
    parse_result_t expected_replies [$];
    int unsigned   mismatches;
    int unsigned   items_in;
    int unsigned   replies_checked;
    int unsigned   status_seen;
    int unsigned   speed_seen;

    function new();
        timeout_ms = TIMEOUT_RST;
        addr_y = ADDR_Y_RST;
        addr_x = ADDR_X_RST;
        fill = 0;
        silence = 8'd0;
        last_status = 8'd0;
        err_count = 32'd0;
        mismatches = 0;
        items_in = 0;
        replies_checked = 0;
        status_seen = 0;
        speed_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            REG_TIMEOUT: timeout_ms = value;
            REG_ADDR_Y:  addr_y = value;
            REG_ADDR_X:  addr_x = value;
            default: ;
        endcase
    endfunction

    function void shift_out(int unsigned n);
        if (n >= fill) begin
            fill = 0;
        end else begin
            for (int i = 0; i < fill - n; i++)
                win[i] = win[i + n];
            fill = fill - n;
        end
    endfunction

    function bit known_command(logic [7:0] b);
        case (b)
            CMD_4A, CMD_F3, CMD_F5, CMD_F6, CMD_FB, CMD_FD,
            CMD_93, CMD_9A, CMD_9C, CMD_SPEED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function bit known_status(logic [7:0] b);
        case (b)
            STS_OK, STS_BUSY, STS_ERR_PARM, STS_ERR_FRM, STS_DONE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void note_item(func_t fn, logic [7:0] b);
        parse_result_t r;
        int            mag;
        int            quot;
        int            raw_val;
        int            rpm_val;
        r = '0;
        items_in++;
        case (fn)
            FN_BYTE: begin
                if (fill >= WIN_LEN)
                    shift_out(1);
                win[fill] = b;
                fill++;
                silence = 8'd0;
                while (fill > 0) begin
                    if (win[0] != addr_y && win[0] != addr_x) begin
                        shift_out(1);
                        continue;
                    end
                    if (fill < 2)
                        break;
                    if (!known_command(win[1])) begin
                        shift_out(1);
                        continue;
                    end
                    if (win[1] == CMD_SPEED) begin
                        if (fill < 6)
                            break;
                        if ((win[2] != DIR_NEG && win[2] != DIR_POS) || win[5] != CHECK_BYTE) begin
                            shift_out(1);
                            continue;
                        end
                        mag = {win[3], win[4]};
                        quot = mag / int'(SPEED_SCALE);
                        raw_val = (win[2] == DIR_POS) ? mag : -mag;
                        rpm_val = (win[2] == DIR_POS) ? quot : -quot;
                        r.accepted = ACC_SPEED;
                        r.axis = (win[0] == addr_y) ? 1'b0 : 1'b1;
                        r.status_error = 1'b0;
                        r.speed_raw = raw_val[16:0];
                        r.speed_rpm = rpm_val[16:0];
                        shift_out(6);
                        continue;
                    end
                    if (fill < 3)
                        break;
                    if (!known_status(win[2])) begin
                        shift_out(1);
                        continue;
                    end
                    if (fill < 4)
                        break;
                    if (win[3] != CHECK_BYTE) begin
                        shift_out(1);
                        continue;
                    end
                    last_status = win[2];
                    r.accepted = ACC_STATUS;
                    r.axis = (win[0] == addr_y) ? 1'b0 : 1'b1;
                    r.speed_raw = '0;
                    r.speed_rpm = '0;
                    r.status_error = (win[2] == STS_ERR_PARM || win[2] == STS_ERR_FRM);
                    if (r.status_error && err_count != 32'hFFFF_FFFF)
                        err_count++;
                    shift_out(4);
                end
            end
            FN_TICK: begin
                if (silence != 8'hFF)
                    silence++;
            end
            FN_STALE: begin
                if (fill > 0 && silence >= timeout_ms) begin
                    fill = 0;
                    silence = 8'd0;
                end
            end
            default: begin
                err_count = 32'd0;
                last_status = 8'd0;
            end
        endcase
        r.status_code = last_status;
        r.error_total = err_count;
        r.window_fill = fill[2:0];
        expected_replies.push_back(r);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task compare_field(string name, logic signed [63:0] got, logic signed [63:0] want);
        if (got !== want)
            report($sformatf("reply %0d: %s is %0d, expected %0d",
                             replies_checked, name, got, want));
    endtask

    task check_reply(parse_result_t got);
        parse_result_t want;
        if (expected_replies.size() == 0) begin
            report("reply arrived with no item outstanding");
            return;
        end
        want = expected_replies.pop_front();
        compare_field("accepted", got.accepted, want.accepted);
        compare_field("axis", got.axis, want.axis);
        compare_field("status_code", got.status_code, want.status_code);
        compare_field("status_error", got.status_error, want.status_error);
        compare_field("error_total", got.error_total, want.error_total);
        compare_field("speed_raw", got.speed_raw, want.speed_raw);
        compare_field("speed_rpm", got.speed_rpm, want.speed_rpm);
        compare_field("window_fill", got.window_fill, want.window_fill);
        if (want.accepted == ACC_STATUS)
            status_seen++;
        if (want.accepted == ACC_SPEED)
            speed_seen++;
        replies_checked++;
    endtask

    task close_out();
        if (expected_replies.size() != 0)
            report($sformatf("%0d replies never arrived", expected_replies.size()));
    endtask
endclass

module stepper_reply_frame_parser_core_test;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 36;

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   phase_start;
    int   idle_cycles;

    logic [7:0] tx_frame [$];

    reply_scoreboard sb = new();

    srfp_req_if req_ch ();
    srfp_rsp_if rsp_ch ();
    srfp_cfg_if cfg_ch ();

    stepper_reply_frame_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_item(func_t fn, logic [7:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= fn;
        req_ch.rx_byte <= data;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_item(fn, data);
    endtask

    task automatic send_frame();
        foreach (tx_frame[i])
            send_item(FN_BYTE, tx_frame[i]);
        tx_frame.delete();
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_replies.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 8))
            0: return CMD_4A;
            1: return CMD_F3;
            2: return CMD_F5;
            3: return CMD_F6;
            4: return CMD_FB;
            5: return CMD_FD;
            6: return CMD_93;
            7: return CMD_9A;
            default: return CMD_9C;
        endcase
    endfunction

    function automatic logic [7:0] pick_status();
        case ($urandom_range(0, 4))
            0: return STS_OK;
            1: return STS_BUSY;
            2: return STS_ERR_PARM;
            3: return STS_ERR_FRM;
            default: return STS_DONE;
        endcase
    endfunction

    task automatic send_random_sequence();
        int          kind;
        int          n;
        logic [7:0]  lead;
        logic [7:0]  dir;
        logic [15:0] mag;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7)
            lead = $urandom_range(0, 1) ? sb.addr_y : sb.addr_x;
        else
            lead = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
            dir = 8'($urandom);
        else
            dir = $urandom_range(0, 1) ? DIR_POS : DIR_NEG;
        case ($urandom_range(0, 5))
            0: mag = 16'hFFFF;
            1: mag = 16'h0000;
            2: mag = 16'($urandom_range(0, 19));
            default: mag = 16'($urandom);
        endcase
        if (kind < 60)
        begin
            if (kind < 35)
                tx_frame = '{lead, pick_command(), pick_status(), CHECK_BYTE};
            else
                tx_frame = '{lead, CMD_SPEED, dir, mag[15:8], mag[7:0], CHECK_BYTE};
            if ($urandom_range(0, 9) == 0)
                tx_frame[$urandom_range(0, tx_frame.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                void'(tx_frame.pop_back());
            send_frame();
        end
        else if (kind < 75)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(FN_BYTE, 8'($urandom));
        end
        else if (kind < 86)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(FN_TICK, 8'($urandom));
            if ($urandom_range(0, 1))
                send_item(FN_STALE, 8'($urandom));
        end
        else if (kind < 95)
        begin
            send_item(FN_STALE, 8'($urandom));
        end
        else
        begin
            send_item(FN_CLEAR, 8'($urandom));
        end
    endtask

    initial
    begin
        parse_result_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.accepted = rsp_ch.accepted;
                got.axis = rsp_ch.axis;
                got.status_code = rsp_ch.status_code;
                got.status_error = rsp_ch.status_error;
                got.error_total = rsp_ch.error_total;
                got.speed_raw = rsp_ch.speed_raw;
                got.speed_rpm = rsp_ch.speed_rpm;
                got.window_fill = rsp_ch.window_fill;
                sb.check_reply(got);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired after %0d cycles without a handshake.", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int         send_pct [4];
        int         stall_pct [4];
        logic [7:0] timeouts [PHASES];
        logic [7:0] y_addrs [PHASES];
        logic [7:0] x_addrs [PHASES];
        send_pct = '{0, 82, 0, 18};
        stall_pct = '{0, 0, 82, 18};
        timeouts = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd4, 8'd2, 8'd5, 8'd3};
        y_addrs = '{8'h01, 8'h00, 8'hFF, 8'h07, 8'h6B, 8'h01, 8'h80, 8'h10};
        x_addrs = '{8'h02, 8'hFF, 8'h00, 8'h07, 8'h35, 8'h02, 8'h7F, 8'h11};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_BYTE;
        req_ch.rx_byte = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = REG_TIMEOUT;
        cfg_ch.data = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_frame = '{8'h01, CMD_F3, STS_ERR_FRM, CHECK_BYTE};
        send_frame();
        tx_frame = '{8'h02, CMD_SPEED, DIR_POS, 8'hFF, 8'hFF, CHECK_BYTE};
        send_frame();
        tx_frame = '{8'h01, CMD_SPEED, DIR_NEG, 8'h12, 8'h34, 8'h6A};
        send_frame();
        tx_frame = '{8'h02, CMD_FD};
        send_frame();
        repeat (3) send_item(FN_TICK, 8'h00);
        send_item(FN_STALE, 8'hFF);
        send_item(FN_CLEAR, 8'h00);
        send_item(FN_BYTE, 8'hFF);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                repeat (2) @(posedge clk);
                write_reg(REG_TIMEOUT, timeouts[p]);
                write_reg(REG_ADDR_Y, y_addrs[p]);
                write_reg(REG_ADDR_X, x_addrs[p]);
            end
            sender_idle_pct = send_pct[p % 4];
            receiver_stall_pct = stall_pct[p % 4];
            if (timeouts[p] == 8'd255)
            begin
                // Silence one short of the timeout keeps the partial frame; it then saturates.
                send_item(FN_BYTE, y_addrs[p]);
                repeat (254) send_item(FN_TICK, 8'h00);
                send_item(FN_STALE, 8'h00);
                repeat (6) send_item(FN_TICK, 8'h00);
                send_item(FN_STALE, 8'h00);
            end
            phase_start = sb.items_in;
            while (sb.items_in - phase_start < PHASE_ITEMS / 2)
                send_random_sequence();
            wait_drained();
            while (sb.items_in - phase_start < PHASE_ITEMS)
                send_random_sequence();
        end

        wait_drained();
        repeat (16) @(posedge clk);
        sb.close_out();
        $display("Ran %0d items over %0d register settings and four idling patterns.",
                 sb.items_in, PHASES);
        $display("Checked %0d replies: %0d status and %0d speed replies accepted.",
                 sb.replies_checked, sb.status_seen, sb.speed_seen);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ stepper_reply_frame_parser_core.f @@
+incdir+rtl
rtl/srfp_pkg.sv
rtl/srfp_if.sv
rtl/srfp_front.sv
rtl/srfp_back.sv
rtl/stepper_reply_frame_parser_core.sv
rtl/srfp_checker.sv
dv/stepper_reply_frame_parser_core_test.sv
